@@ design/bta_pkg.sv @@
// Package for the bakery ticket arbiter: request modes, field widths, stream widths and the active-count reset value.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bta_pkg;

	localparam int MODE_W      = 2;
	localparam int THREAD_W    = 4;
	localparam int CFG_W       = 5;
	localparam int TICKET_W    = 16;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	localparam logic [MODE_W-1:0] MODE_TAKE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POLL    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

	localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

endpackage
`default_nettype wire

@@ design/bakery_ticket_arbiter_top.sv @@
// Bakery ticket arbiter: ticket table in a synchronous RAM, one scan per request.
// Depends on bta_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Each request (take a ticket, poll for the grant, release) is answered by one
// result. The block scans the active slots of the ticket RAM, one read per
// cycle, collecting the largest ticket and the lowest other nonzero ticket, then
// writes the slot back and loads the result register. A request scans n slots, n
// being the effective active thread count, and then passes a drain state before
// its result; a request naming an inactive slot skips the scan. The write-back
// waits while the previous result is still unread on the output.
// A new request is accepted while the previous result waits on the output.
// Ticket valid bits are cleared by reset, so no clearing pass is needed.
// active_threads may be written only while the block is idle.
module bakery_ticket_arbiter_top #(
	parameter int MAX_THREADS = 16,
	parameter int TICKET_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// [1:0] mode, [5:2] thread_index, [7:6] zero
	input  wire  [bta_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// [15:0] ticket, [16] granted, [17] ticket_saturated, [23:18] zero
	output logic [bta_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [bta_pkg::CFG_W-1:0]        cfg_data
);

	localparam int AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CW = bta_pkg::CFG_W;
	localparam logic [CW:0] MAX_N = (MAX_THREADS > 31) ? 6'd31 : 6'(MAX_THREADS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                     state_q;
	logic [CW-1:0]                  active_q;
	logic [CW-1:0]                  n_eff;
	logic [bta_pkg::MODE_W-1:0]     mode_q;
	logic [bta_pkg::THREAD_W-1:0]   slot_q;
	logic                           inactive_q;
	logic [CW-1:0]                  idx_q;
	logic [CW-1:0]                  n_q;

	logic [TICKET_BITS-1:0]         ticket_mem_q [MAX_THREADS];
	logic [MAX_THREADS-1:0]         valid_q;
	logic [AW-1:0]                  rd_addr;
	logic [TICKET_BITS-1:0]         rd_data_s1;
	logic                           rd_hit_s1;
	logic                           rd_vld_s1;
	logic [CW-1:0]                  rd_idx_s1;
	logic [TICKET_BITS-1:0]         rd_val;

	logic [TICKET_BITS-1:0]         max_q;
	logic [TICKET_BITS-1:0]         min_q;
	logic [CW-1:0]                  min_idx_q;
	logic                           min_any_q;
	logic [TICKET_BITS-1:0]         old_q;

	logic                           accept;
	logic                           issue;
	logic                           done_go;
	logic [TICKET_BITS-1:0]         fresh;
	logic [TICKET_BITS-1:0]         mine;
	logic                           granted;
	logic                           sat;
	logic                           wr_en;
	logic [bta_pkg::MODE_W-1:0]     in_mode;
	logic [bta_pkg::THREAD_W-1:0]   in_slot;

	assign in_mode   = s_tdata[1:0];
	assign in_slot   = s_tdata[5:2];
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (active_q == '0) begin
			n_eff = CW'(1);
		end else if ({1'b0, active_q} > MAX_N) begin
			n_eff = MAX_N[CW-1:0];
		end else begin
			n_eff = active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= bta_pkg::ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	assign issue   = (state_q == ST_SCAN);
	assign done_go = (state_q == ST_DONE) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ({1'b0, in_slot} >= n_eff) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == n_q - CW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (done_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= in_mode;
			slot_q     <= in_slot;
			n_q        <= n_eff;
			inactive_q <= ({1'b0, in_slot} >= n_eff);
			idx_q      <= '0;
		end else if (issue) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	// ticket RAM, one read per scan cycle, written back at the end of a request
	assign rd_addr = AW'(idx_q);
	assign wr_en   = done_go && !inactive_q
		&& (mode_q == bta_pkg::MODE_TAKE || mode_q == bta_pkg::MODE_RELEASE);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ticket_mem_q[AW'(slot_q)] <= mine;
		end
		rd_data_s1 <= ticket_mem_q[rd_addr];
		rd_idx_s1  <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_hit_s1 <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[AW'(slot_q)] <= 1'b1;
			end
			rd_hit_s1 <= valid_q[rd_addr];
			rd_vld_s1 <= issue;
		end
	end

	assign rd_val = rd_hit_s1 ? rd_data_s1 : '0;

	// scan: running max over all slots, lowest nonzero ticket over the others
	always_ff @(posedge clk) begin
		if (accept) begin
			max_q     <= '0;
			min_q     <= '0;
			min_idx_q <= '0;
			min_any_q <= 1'b0;
			old_q     <= '0;
		end else if (rd_vld_s1) begin
			if (rd_val > max_q) begin
				max_q <= rd_val;
			end
			if (rd_idx_s1 == {1'b0, slot_q}) begin
				old_q <= rd_val;
			end else if (rd_val != '0 && (!min_any_q || rd_val < min_q)) begin
				min_q     <= rd_val;
				min_idx_q <= rd_idx_s1;
				min_any_q <= 1'b1;
			end
		end
	end

	always_comb begin
		fresh = (&max_q) ? max_q : TICKET_BITS'(max_q + 1'b1);
		case (mode_q)
			bta_pkg::MODE_TAKE:    mine = fresh;
			bta_pkg::MODE_RELEASE: mine = '0;
			default:               mine = old_q;
		endcase
		granted = (mine != '0) && (!min_any_q || mine < min_q
			|| (mine == min_q && {1'b0, slot_q} < min_idx_q));
		sat = (mode_q == bta_pkg::MODE_TAKE) && (&fresh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (done_go) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) begin
			if (inactive_q) begin
				m_tdata <= '0;
			end else begin
				m_tdata <= {6'd0, sat, granted, bta_pkg::TICKET_W'(mine)};
			end
		end
	end

endmodule
`default_nettype wire
